@@ src/aqu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the AHRS quaternion update block.
// No dependencies; used by every other file in src except aqu_fifo.
package aqu_pkg;

  typedef logic signed [31:0] s32_t;
  typedef logic signed [30:0] hg_t;
  typedef hg_t [2:0] hg_vec_t;

  typedef struct packed {
    s32_t [3:0]  quat;
    s32_t [2:0]  rate;
    s32_t [2:0]  accel;
    logic [31:0] time_step;
    logic [31:0] feedback_gain;
  } in_item_t;

  typedef struct packed {
    s32_t [3:0]  quat;
    s32_t [2:0]  rate;
    s32_t [2:0]  fbk;
    logic [31:0] time_step;
    logic [31:0] feedback_gain;
  } mid_item_t;

  typedef struct packed {
    s32_t [3:0] quat;
  } out_item_t;

  localparam logic [1:0] CFG_HG_X = 2'd0;
  localparam logic [1:0] CFG_HG_Y = 2'd1;
  localparam logic [1:0] CFG_HG_Z = 2'd2;

  localparam hg_t HG_RESET_X = 31'sd0;
  localparam hg_t HG_RESET_Y = 31'sd0;
  localparam hg_t HG_RESET_Z = 31'sd536870912;

  localparam logic [31:0] RSQRT_MAGIC = 32'h5F1F1412;
  localparam logic [30:0] RSQRT_C1    = 31'd1814626163;
  localparam logic [29:0] RSQRT_C2    = 30'd766821494;
  localparam int          HALF_RAD_K  = 37480660;

  localparam int EXP_BIAS  = 127;
  localparam int ACC_FRAC  = 16;
  localparam int UNIT_FRAC = 30;
  localparam int MS_FRAC   = 32;
  localparam int CS_FRAC   = 60;
  localparam int RSQ_LAT   = 8;

  localparam int MID_DEPTH_DEF = 32;
  localparam int OUT_DEPTH_DEF = 16;

  localparam logic signed [71:0] SAT_MAX = 72'sd2147483647;
  localparam logic signed [71:0] SAT_MIN = -72'sd2147483648;

  function automatic s32_t sat32(input logic signed [71:0] v);
    s32_t res;
    if (v > SAT_MAX) begin
      res = 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

@@ src/aqu_fifo.sv @@
`timescale 1ns / 1ps
// Small register-based first-in first-out queue used between and after the
// front and back sections. No package dependency.
module aqu_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(wr_en) - CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign empty   = (cnt_r == '0);

endmodule

@@ src/aqu_rsqrt.sv @@
`timescale 1ns / 1ps
// Pipelined inverse square root estimate with one refinement step.
// Depends on aqu_pkg for constants.
module aqu_rsqrt #(
  parameter int FRAC_BITS = aqu_pkg::MS_FRAC
) (
  input  logic               clk,
  input  logic [63:0]        m_i,
  output logic signed [33:0] im_o,
  output logic [7:0]         er_o
);

  function automatic logic [5:0] msb_pos(input logic [63:0] v);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        pos = 6'(i);
      end
    end
    return pos;
  endfunction

  logic [63:0]        m1_r;
  logic [5:0]         n1_r;
  logic [23:0]        mx2_r, mx3_r;
  logic signed [9:0]  ex2_r, ex3_r;
  logic [7:0]         e2_r, e3_r, e4_r, e5_r, e6_r, e7_r, er_r;
  logic [23:0]        my2_r, my3_r, my4_r, my5_r, my6_r, my7_r;
  logic [24:0]        p3_r;
  logic [25:0]        q4_r;
  logic signed [10:0] k4_r;
  logic [31:0]        t5_r;
  logic [61:0]        prod6_r;
  logic signed [33:0] c7_r;
  logic signed [33:0] im_r;

  logic [63:0]        mx_w;
  logic signed [9:0]  ex2;
  logic [30:0]        pat;
  logic [31:0]        r2;
  logic [47:0]        pp;
  logic [48:0]        qp;
  logic signed [10:0] k4;
  logic [63:0]        tsh;
  logic [10:0]        negk;
  logic [31:0]        t5;
  logic [61:0]        prod6;
  logic signed [33:0] c7;
  logic signed [58:0] imp;

  always_comb begin
    mx_w = (n1_r >= 6'd23) ? (m1_r >> (n1_r - 6'd23)) : (m1_r << (6'd23 - n1_r));
    ex2  = $signed({4'b0000, n1_r}) - 10'(FRAC_BITS);
    pat  = {8'(ex2 + 10'(aqu_pkg::EXP_BIAS)), mx_w[22:0]};
    r2   = aqu_pkg::RSQRT_MAGIC - {2'b00, pat[30:1]};
    pp   = my2_r * my2_r;
    qp   = mx3_r * p3_r;
    k4   = $signed({ex3_r[9], ex3_r}) + $signed({2'b00, e3_r, 1'b0}) - 11'sd247;
  end

  always_comb begin
    tsh  = '0;
    negk = '0;
    if (!k4_r[10]) begin
      if (k4_r >= 11'sd32) begin
        t5 = '1;
      end else begin
        tsh = {38'b0, q4_r} << k4_r[4:0];
        t5  = (|tsh[63:32]) ? '1 : tsh[31:0];
      end
    end else begin
      negk = 11'(-k4_r);
      if (negk >= 11'd32) begin
        t5 = '0;
      end else begin
        tsh = {38'b0, q4_r} >> negk[4:0];
        t5  = tsh[31:0];
      end
    end
    prod6 = aqu_pkg::RSQRT_C2 * t5_r;
    c7    = $signed({3'b000, aqu_pkg::RSQRT_C1}) - $signed({2'b00, prod6_r[61:30]});
    imp   = $signed({1'b0, my7_r}) * c7_r;
  end

  always_ff @(posedge clk) begin
    m1_r    <= m_i;
    n1_r    <= msb_pos(m_i);
    mx2_r   <= mx_w[23:0];
    ex2_r   <= ex2;
    e2_r    <= r2[30:23];
    my2_r   <= {1'b1, r2[22:0]};
    p3_r    <= pp[47:23];
    mx3_r   <= mx2_r;
    ex3_r   <= ex2_r;
    e3_r    <= e2_r;
    my3_r   <= my2_r;
    q4_r    <= qp[48:23];
    k4_r    <= k4;
    e4_r    <= e3_r;
    my4_r   <= my3_r;
    t5_r    <= t5;
    e5_r    <= e4_r;
    my5_r   <= my4_r;
    prod6_r <= prod6;
    e6_r    <= e5_r;
    my6_r   <= my5_r;
    c7_r    <= c7;
    e7_r    <= e6_r;
    my7_r   <= my6_r;
    im_r    <= imp[56:23];
    er_r    <= e7_r;
  end

  assign im_o = im_r;
  assign er_o = er_r;

endmodule

@@ src/aqu_front.sv @@
`timescale 1ns / 1ps
// Front section: accepts samples, normalizes the accel vector and forms the
// feedback term. Depends on aqu_pkg and aqu_rsqrt.
module aqu_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  aqu_pkg::in_item_t   in_item,
  input  aqu_pkg::hg_vec_t    hg,
  output logic                mid_vld,
  output aqu_pkg::mid_item_t  mid_item
);

  localparam int S_SQ  = 1;
  localparam int S_MS  = S_SQ + 1;
  localparam int S_IM1 = S_MS + aqu_pkg::RSQ_LAT;
  localparam int S_PR1 = S_IM1 + 1;
  localparam int S_N   = S_PR1 + 1;
  localparam int S_XP  = S_N + 1;
  localparam int S_FBK = S_XP + 1;
  localparam int S_FSQ = S_FBK + 1;
  localparam int S_CS  = S_FSQ + 1;
  localparam int S_IM2 = S_CS + aqu_pkg::RSQ_LAT;
  localparam int S_PR2 = S_IM2 + 1;
  localparam int S_FR  = S_PR2 + 1;
  localparam int S_SEL = S_FR + 1;

  localparam logic signed [9:0] SH1_BASE = 10'(aqu_pkg::ACC_FRAC + aqu_pkg::EXP_BIAS);
  localparam logic signed [9:0] SH2_BASE = 10'(aqu_pkg::UNIT_FRAC + aqu_pkg::EXP_BIAS);

  logic [S_SEL:0]       vld_r;
  aqu_pkg::in_item_t    item_r [0:S_FR];
  logic                 azero_r [S_SQ:S_FR];
  logic                 neg_r [S_FBK:S_FR];
  logic                 nz_r [S_CS:S_FR];
  aqu_pkg::s32_t        fbk_r [S_FBK:S_FR][3];

  logic [63:0]          sq_r [3];
  logic [63:0]          ms_r;
  logic signed [65:0]   pr1_r [3];
  logic [7:0]           sh1_r;
  aqu_pkg::s32_t        n_r [3];
  logic signed [63:0]   xp_r [6];
  logic signed [63:0]   dp_r [3];
  logic [63:0]          fsq_r [3];
  logic [63:0]          cs_r;
  logic signed [65:0]   pr2_r [3];
  logic [7:0]           sh2_r;
  aqu_pkg::s32_t        fr_r [3];
  aqu_pkg::mid_item_t   mid_r;

  logic signed [33:0]   im1, im2;
  logic [7:0]           er1, er2;
  logic signed [9:0]    sh1, sh2;
  logic signed [65:0]   dsum;
  logic [63:0]          csum;

  aqu_rsqrt #(.FRAC_BITS(aqu_pkg::MS_FRAC)) u_rsq_acc (
    .clk  (clk),
    .m_i  (ms_r),
    .im_o (im1),
    .er_o (er1)
  );

  aqu_rsqrt #(.FRAC_BITS(aqu_pkg::CS_FRAC)) u_rsq_fbk (
    .clk  (clk),
    .m_i  (cs_r),
    .im_o (im2),
    .er_o (er2)
  );

  always_comb begin
    sh1  = SH1_BASE - $signed({2'b00, er1});
    sh2  = SH2_BASE - $signed({2'b00, er2});
    dsum = dp_r[0] + dp_r[1] + dp_r[2];
    csum = fsq_r[0] + fsq_r[1] + fsq_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[S_SEL-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    item_r[0] <= in_item;
    for (int s = 1; s <= S_FR; s++) begin
      item_r[s] <= item_r[s-1];
    end
    azero_r[S_SQ] <= (item_r[0].accel == '0);
    for (int s = S_SQ + 1; s <= S_FR; s++) begin
      azero_r[s] <= azero_r[s-1];
    end
    neg_r[S_FBK] <= dsum[65];
    for (int s = S_FBK + 1; s <= S_FR; s++) begin
      neg_r[s] <= neg_r[s-1];
    end
    nz_r[S_CS] <= (csum != '0);
    for (int s = S_CS + 1; s <= S_FR; s++) begin
      nz_r[s] <= nz_r[s-1];
    end
    for (int s = S_FBK + 1; s <= S_FR; s++) begin
      fbk_r[s] <= fbk_r[s-1];
    end

    for (int i = 0; i < 3; i++) begin
      sq_r[i]  <= 64'($signed(item_r[0].accel[i]) * $signed(item_r[0].accel[i]));
      pr1_r[i] <= $signed(item_r[S_IM1].accel[i]) * im1;
      n_r[i]   <= aqu_pkg::sat32(72'(pr1_r[i] >>> sh1_r));
      dp_r[i]  <= $signed(n_r[i]) * $signed(hg[i]);
      fsq_r[i] <= 64'($signed(fbk_r[S_FBK][i]) * $signed(fbk_r[S_FBK][i]));
      pr2_r[i] <= $signed(fbk_r[S_IM2][i]) * im2;
      fr_r[i]  <= aqu_pkg::sat32(72'(pr2_r[i] >>> sh2_r));
    end
    ms_r  <= sq_r[0] + sq_r[1] + sq_r[2];
    sh1_r <= sh1[9] ? '0 : sh1[7:0];
    sh2_r <= sh2[9] ? '0 : sh2[7:0];

    xp_r[0] <= $signed(n_r[1]) * $signed(hg[2]);
    xp_r[1] <= $signed(n_r[2]) * $signed(hg[1]);
    xp_r[2] <= $signed(n_r[2]) * $signed(hg[0]);
    xp_r[3] <= $signed(n_r[0]) * $signed(hg[2]);
    xp_r[4] <= $signed(n_r[0]) * $signed(hg[1]);
    xp_r[5] <= $signed(n_r[1]) * $signed(hg[0]);

    fbk_r[S_FBK][0] <= aqu_pkg::sat32(72'((xp_r[0] - xp_r[1]) >>> aqu_pkg::UNIT_FRAC));
    fbk_r[S_FBK][1] <= aqu_pkg::sat32(72'((xp_r[2] - xp_r[3]) >>> aqu_pkg::UNIT_FRAC));
    fbk_r[S_FBK][2] <= aqu_pkg::sat32(72'((xp_r[4] - xp_r[5]) >>> aqu_pkg::UNIT_FRAC));
    cs_r <= csum;

    mid_r.quat          <= item_r[S_FR].quat;
    mid_r.rate          <= item_r[S_FR].rate;
    mid_r.time_step     <= item_r[S_FR].time_step;
    mid_r.feedback_gain <= item_r[S_FR].feedback_gain;
    for (int i = 0; i < 3; i++) begin
      if (azero_r[S_FR]) begin
        mid_r.fbk[i] <= '0;
      end else if (neg_r[S_FR] && nz_r[S_FR]) begin
        mid_r.fbk[i] <= fr_r[i];
      end else begin
        mid_r.fbk[i] <= fbk_r[S_FR][i];
      end
    end
  end

  assign mid_vld  = vld_r[S_SEL];
  assign mid_item = mid_r;

endmodule

@@ src/aqu_back.sv @@
`timescale 1ns / 1ps
// Back section: adds feedback to the gyro rates and integrates the quaternion.
// Depends on aqu_pkg.
module aqu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  aqu_pkg::mid_item_t  mid_item,
  output logic                out_vld,
  output aqu_pkg::out_item_t  out_item
);

  localparam int LB = 7;

  logic [LB-1:0]       vld_r;
  aqu_pkg::s32_t       q_r [0:5][4];
  logic [31:0]         dt_r [0:3];
  logic signed [63:0]  hr_r [3];
  logic signed [65:0]  fg_r [3];
  logic signed [31:0]  adj_r [3];
  logic signed [63:0]  qa_r [4][3];
  logic signed [45:0]  d_r [4];
  logic signed [63:0]  ph_r [4];
  logic signed [63:0]  pl_r [4];
  logic signed [47:0]  inc_r [4];
  aqu_pkg::out_item_t  out_r;

  logic signed [67:0]  asum [3];
  logic signed [65:0]  dq [4];
  logic signed [64:0]  isum [4];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      asum[i] = (hr_r[i] >>> 18) + (fg_r[i] >>> 24);
    end
    dq[0] = -qa_r[1][0] - qa_r[2][1] - qa_r[3][2];
    dq[1] =  qa_r[0][0] + qa_r[2][2] - qa_r[3][1];
    dq[2] =  qa_r[0][1] - qa_r[1][2] + qa_r[3][0];
    dq[3] =  qa_r[0][2] + qa_r[1][1] - qa_r[2][0];
    for (int i = 0; i < 4; i++) begin
      isum[i] = ph_r[i] + (pl_r[i] >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LB-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      q_r[0][i] <= mid_item.quat[i];
    end
    for (int s = 1; s <= 5; s++) begin
      q_r[s] <= q_r[s-1];
    end
    dt_r[0] <= mid_item.time_step;
    for (int s = 1; s <= 3; s++) begin
      dt_r[s] <= dt_r[s-1];
    end
    for (int i = 0; i < 3; i++) begin
      hr_r[i]  <= $signed(mid_item.rate[i]) * aqu_pkg::HALF_RAD_K;
      fg_r[i]  <= $signed(mid_item.fbk[i]) * $signed({1'b0, mid_item.feedback_gain});
      adj_r[i] <= asum[i][41:10];
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) begin
        qa_r[i][j] <= $signed(q_r[1][i]) * adj_r[j];
      end
      d_r[i]   <= dq[i][65:20];
      ph_r[i]  <= d_r[i] * $signed({1'b0, dt_r[3][31:16]});
      pl_r[i]  <= d_r[i] * $signed({1'b0, dt_r[3][15:0]});
      inc_r[i] <= isum[i][63:16];
      out_r.quat[i] <= aqu_pkg::sat32(72'($signed(q_r[5][i]) + inc_r[i]));
    end
  end

  assign out_vld  = vld_r[LB-1];
  assign out_item = out_r;

endmodule

@@ src/ahrs_quaternion_update.sv @@
`timescale 1ns / 1ps
// Top level of the AHRS quaternion update block: configuration registers,
// queues and transfer credit logic. Depends on aqu_pkg, aqu_front, aqu_back, aqu_fifo.
//
//   Channel   Handshake               Payload
//   input     in_push / in_full       in_quat_*, in_rate_*, in_accel_*, in_time_step,
//                                     in_feedback_gain
//   result    out_empty / out_pop     out_new_w, out_new_x, out_new_y, out_new_z
//   config    cfg_we                  cfg_index, cfg_data
//
// One sample is taken per clock while in_full is low. With no stalls a result passes
// from its input transfer to the result ports through 28 front stages, the middle
// queue, 7 back stages and the result queue. The front stops taking samples only when
// the middle queue has no free credit; the back holds items in the middle queue
// when the result queue has no free credit. Reset is synchronous, clears the
// queues and credits and loads the half gravity registers with their reset values.
module ahrs_quaternion_update #(
  parameter int MID_DEPTH = aqu_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = aqu_pkg::OUT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [31:0] in_quat_w,
  input  logic signed [31:0] in_quat_x,
  input  logic signed [31:0] in_quat_y,
  input  logic signed [31:0] in_quat_z,
  input  logic signed [31:0] in_rate_x,
  input  logic signed [31:0] in_rate_y,
  input  logic signed [31:0] in_rate_z,
  input  logic signed [31:0] in_accel_x,
  input  logic signed [31:0] in_accel_y,
  input  logic signed [31:0] in_accel_z,
  input  logic [31:0]        in_time_step,
  input  logic [31:0]        in_feedback_gain,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_new_w,
  output logic signed [31:0] out_new_x,
  output logic signed [31:0] out_new_y,
  output logic signed [31:0] out_new_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  localparam int MCW = $clog2(MID_DEPTH + 1);
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  aqu_pkg::hg_vec_t   hg_r;
  logic [MCW-1:0]     front_cnt_r, front_cnt_nxt;
  logic [OCW-1:0]     back_cnt_r, back_cnt_nxt;

  aqu_pkg::in_item_t  in_item;
  aqu_pkg::mid_item_t front_item, mid_head;
  aqu_pkg::out_item_t back_item, out_head;
  logic               in_accept, out_accept;
  logic               front_vld, back_vld;
  logic               mid_empty, mid_pop;

  always_comb begin
    in_item.quat[0]       = in_quat_w;
    in_item.quat[1]       = in_quat_x;
    in_item.quat[2]       = in_quat_y;
    in_item.quat[3]       = in_quat_z;
    in_item.rate[0]       = in_rate_x;
    in_item.rate[1]       = in_rate_y;
    in_item.rate[2]       = in_rate_z;
    in_item.accel[0]      = in_accel_x;
    in_item.accel[1]      = in_accel_y;
    in_item.accel[2]      = in_accel_z;
    in_item.time_step     = in_time_step;
    in_item.feedback_gain = in_feedback_gain;
  end

  assign in_full    = (front_cnt_r == MCW'(MID_DEPTH));
  assign in_accept  = in_push && !in_full;
  assign mid_pop    = !mid_empty && (back_cnt_r != OCW'(OUT_DEPTH));
  assign out_accept = out_pop && !out_empty;

  always_comb begin
    front_cnt_nxt = front_cnt_r + MCW'(in_accept) - MCW'(mid_pop);
    back_cnt_nxt  = back_cnt_r + OCW'(mid_pop) - OCW'(out_accept);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_cnt_r <= '0;
      back_cnt_r  <= '0;
      hg_r[0]     <= aqu_pkg::HG_RESET_X;
      hg_r[1]     <= aqu_pkg::HG_RESET_Y;
      hg_r[2]     <= aqu_pkg::HG_RESET_Z;
    end else begin
      front_cnt_r <= front_cnt_nxt;
      back_cnt_r  <= back_cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          aqu_pkg::CFG_HG_X: hg_r[0] <= cfg_data;
          aqu_pkg::CFG_HG_Y: hg_r[1] <= cfg_data;
          aqu_pkg::CFG_HG_Z: hg_r[2] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  aqu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_accept),
    .in_item  (in_item),
    .hg       (hg_r),
    .mid_vld  (front_vld),
    .mid_item (front_item)
  );

  aqu_fifo #(
    .WIDTH ($bits(aqu_pkg::mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (front_vld),
    .wr_data (front_item),
    .rd_en   (mid_pop),
    .rd_data (mid_head),
    .empty   (mid_empty)
  );

  aqu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (mid_pop),
    .mid_item (mid_head),
    .out_vld  (back_vld),
    .out_item (back_item)
  );

  aqu_fifo #(
    .WIDTH ($bits(aqu_pkg::out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (back_vld),
    .wr_data (back_item),
    .rd_en   (out_accept),
    .rd_data (out_head),
    .empty   (out_empty)
  );

  assign out_new_w = out_head.quat[0];
  assign out_new_x = out_head.quat[1];
  assign out_new_y = out_head.quat[2];
  assign out_new_z = out_head.quat[3];

  a_front_credit: assert property (@(posedge clk) disable iff (!rst_n)
    front_cnt_r <= MCW'(MID_DEPTH))
    else $error("front credit count exceeds middle queue depth");

  a_back_credit: assert property (@(posedge clk) disable iff (!rst_n)
    back_cnt_r <= OCW'(OUT_DEPTH))
    else $error("back credit count exceeds result queue depth");

  a_mid_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (front_cnt_r == '0) |-> mid_empty)
    else $error("middle queue holds an item with no front credit in use");

  a_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (back_cnt_r == '0) |-> out_empty)
    else $error("result queue holds an item with no back credit in use");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ahrs_quaternion_update: directed and random samples
// checked against a bit-exact fixed-point predictor. Depends on aqu_pkg and the RTL.
module tb_top;

  typedef logic signed [127:0] wide_t;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  class attitude_scoreboard;
    aqu_pkg::hg_t hg[3];
    aqu_pkg::out_item_t attitude_q[$];
    int mismatches;

    function new();
      hg[0] = aqu_pkg::HG_RESET_X;
      hg[1] = aqu_pkg::HG_RESET_Y;
      hg[2] = aqu_pkg::HG_RESET_Z;
      mismatches = 0;
    endfunction

    function longint clamp32(wide_t v);
      if (v > 128'sd2147483647) return 64'sd2147483647;
      if (v < -128'sd2147483648) return -64'sd2147483648;
      return longint'(v);
    endfunction

    function void inv_sqrt(input logic [63:0] m, input int fb, output longint im, output int er);
      int n, ex, k, e;
      logic [63:0] mx, my, p, q, t;
      logic [31:0] pat, r;
      longint c;
      n = 63;
      while (n > 0 && !m[n]) n--;
      ex = n - fb;
      mx = (n >= 23) ? (m >> (n - 23)) : (m << (23 - n));
      pat = (32'(ex + aqu_pkg::EXP_BIAS) << 23) | {9'b0, mx[22:0]};
      r = aqu_pkg::RSQRT_MAGIC - (pat >> 1);
      e = int'(r[30:23]);
      my = {40'b0, 1'b1, r[22:0]};
      p = (my * my) >> 23;
      q = (mx * p) >> 23;
      k = ex + 2 * e - 247;
      if (k >= 0) begin
        if (k >= 32) t = 64'hFFFFFFFF;
        else begin
          t = q << k;
          if (t > 64'hFFFFFFFF) t = 64'hFFFFFFFF;
        end
      end else begin
        t = (k <= -63) ? 64'd0 : (q >> (-k));
      end
      c = longint'({33'b0, aqu_pkg::RSQRT_C1})
          - longint'((64'(aqu_pkg::RSQRT_C2) * t) >> 30);
      im = (longint'(my) * c) >>> 23;
      er = e;
    endfunction

    function longint scale_unit(longint v, int fb, longint im, int er);
      int sh;
      sh = fb + aqu_pkg::EXP_BIAS - er;
      if (sh < 0) sh = 0;
      return clamp32((wide_t'(v) * wide_t'(im)) >>> sh);
    endfunction

    function longint cross_term(longint a, longint b, longint c, longint d);
      return clamp32(wide_t'(a * b - c * d) >>> 30);
    endfunction

    function aqu_pkg::out_item_t predict(aqu_pkg::in_item_t it);
      longint q[4], g[3], a[3], h[3], fbk[3], nv[3], adj[3], dq[4];
      longint im, dot, dh, dl, d, inc, hr;
      logic [63:0] ms, cs;
      wide_t fg;
      int er;
      aqu_pkg::out_item_t res;
      for (int i = 0; i < 4; i++) q[i] = it.quat[i];
      for (int i = 0; i < 3; i++) begin
        g[i] = it.rate[i];
        a[i] = it.accel[i];
        h[i] = hg[i];
        fbk[i] = 0;
      end
      if (a[0] != 0 || a[1] != 0 || a[2] != 0) begin
        ms = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        inv_sqrt(ms, aqu_pkg::MS_FRAC, im, er);
        for (int i = 0; i < 3; i++) nv[i] = scale_unit(a[i], aqu_pkg::ACC_FRAC, im, er);
        fbk[0] = cross_term(nv[1], h[2], nv[2], h[1]);
        fbk[1] = cross_term(nv[2], h[0], nv[0], h[2]);
        fbk[2] = cross_term(nv[0], h[1], nv[1], h[0]);
        dot = nv[0] * h[0] + nv[1] * h[1] + nv[2] * h[2];
        if (dot < 0) begin
          cs = fbk[0] * fbk[0] + fbk[1] * fbk[1] + fbk[2] * fbk[2];
          if (cs != 0) begin
            inv_sqrt(cs, aqu_pkg::CS_FRAC, im, er);
            for (int i = 0; i < 3; i++)
              fbk[i] = scale_unit(fbk[i], aqu_pkg::UNIT_FRAC, im, er);
          end
        end
      end
      for (int i = 0; i < 3; i++) begin
        hr = (g[i] * longint'(aqu_pkg::HALF_RAD_K)) >>> 18;
        fg = (wide_t'(fbk[i]) * wide_t'(longint'(it.feedback_gain))) >>> 24;
        adj[i] = longint'((wide_t'(hr) + fg) >>> 10);
      end
      dq[0] = -q[1] * adj[0] - q[2] * adj[1] - q[3] * adj[2];
      dq[1] = q[0] * adj[0] + q[2] * adj[2] - q[3] * adj[1];
      dq[2] = q[0] * adj[1] - q[1] * adj[2] + q[3] * adj[0];
      dq[3] = q[0] * adj[2] + q[1] * adj[1] - q[2] * adj[0];
      dh = longint'(it.time_step >> 16);
      dl = longint'(it.time_step & 32'hFFFF);
      for (int i = 0; i < 4; i++) begin
        d = dq[i] >>> 20;
        inc = (d * dh + ((d * dl) >>> 16)) >>> 16;
        res.quat[i] = aqu_pkg::s32_t'(clamp32(wide_t'(q[i] + inc)));
      end
      return res;
    endfunction

    function void note_input(aqu_pkg::in_item_t it);
      attitude_q.push_back(predict(it));
    endfunction

    function void check_result(aqu_pkg::out_item_t got);
      aqu_pkg::out_item_t want;
      if (attitude_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: %h", got);
        return;
      end
      want = attitude_q.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got.quat[i] !== want.quat[i]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Component %0d mismatch: expected %0d, got %0d",
                     i, want.quat[i], got.quat[i]);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [31:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic signed [31:0] in_rate_x = '0, in_rate_y = '0, in_rate_z = '0;
  logic signed [31:0] in_accel_x = '0, in_accel_y = '0, in_accel_z = '0;
  logic [31:0] in_time_step = '0, in_feedback_gain = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [31:0] out_new_w, out_new_x, out_new_y, out_new_z;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = aqu_pkg::CFG_HG_X;
  logic [30:0] cfg_data = '0;

  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  attitude_scoreboard sb = new();

  ahrs_quaternion_update u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_result('{quat: '{out_new_z, out_new_y, out_new_x, out_new_w}});
    if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL ahrs_quaternion_update");
      $finish;
    end
  end

  task automatic push_sample(input aqu_pkg::in_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    {in_quat_z, in_quat_y, in_quat_x, in_quat_w} <= it.quat;
    {in_rate_z, in_rate_y, in_rate_x} <= it.rate;
    {in_accel_z, in_accel_y, in_accel_x} <= it.accel;
    in_time_step <= it.time_step;
    in_feedback_gain <= it.feedback_gain;
    do @(posedge clk); while (in_full);
    sb.note_input(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_push <= 1'b0;
    while (sb.attitude_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_gravity(input logic signed [30:0] gx, input logic signed [30:0] gy,
                               input logic signed [30:0] gz);
    logic [1:0] idx [3] = '{aqu_pkg::CFG_HG_X, aqu_pkg::CFG_HG_Y, aqu_pkg::CFG_HG_Z};
    logic signed [30:0] val [3];
    val = '{gx, gy, gz};
    wait_idle();
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      sb.hg[i] = val[i];
      @(negedge clk);
    end
    cfg_index <= CFG_SPARE;
    cfg_data <= 31'h7FFFFFFF;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic aqu_pkg::in_item_t plausible_sample();
    aqu_pkg::in_item_t it;
    for (int i = 0; i < 4; i++) it.quat[i] = $signed($urandom_range(0, 32'h7FFFFFFF)) >>> 1;
    for (int i = 0; i < 3; i++) begin
      it.rate[i] = $signed($urandom_range(0, 2000 << 16)) - (1000 << 16);
      it.accel[i] = $signed($urandom_range(0, 6 << 16)) - (3 << 16);
    end
    it.time_step = $urandom_range(0, 32'h04000000);
    it.feedback_gain = $urandom_range(0, 32'h08000000);
    return it;
  endfunction

  function automatic aqu_pkg::in_item_t raw_sample();
    aqu_pkg::in_item_t it;
    for (int i = 0; i < 4; i++) it.quat[i] = $urandom;
    for (int i = 0; i < 3; i++) begin
      it.rate[i] = $urandom;
      it.accel[i] = $urandom;
    end
    it.time_step = $urandom;
    it.feedback_gain = $urandom;
    return it;
  endfunction

  task automatic random_phase(input int count);
    for (int n = 0; n < count; n++)
      push_sample(($urandom_range(0, 99) < 80) ? plausible_sample() : raw_sample());
  endtask

  initial begin
    aqu_pkg::in_item_t it;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle = 21;
    recv_idle = 78;
    // Directed samples at the field extremes and around the feedback special cases.
    it = plausible_sample();
    it.accel = '{default: 0};
    push_sample(it);
    it.accel = '{32'sh0, 32'sh0, -32'sh10000};
    push_sample(it);
    it.accel = '{-32'sh10000, 32'sh0, 32'sh0};
    push_sample(it);
    it.accel = '{-32'sh3000, 32'sh200, 32'sh800};
    push_sample(it);
    for (int v = 0; v < 2; v++) begin
      it.quat = '{default: (v == 0) ? 32'sh7FFFFFFF : 32'sh80000000};
      it.rate = '{default: (v == 0) ? 32'sh7FFFFFFF : 32'sh80000000};
      it.accel = '{default: (v == 0) ? 32'sh7FFFFFFF : 32'sh80000000};
      it.time_step = 32'hFFFFFFFF;
      it.feedback_gain = 32'hFFFFFFFF;
      push_sample(it);
      it.accel = '{32'sh1, 32'sh0, 32'sh0};
      it.time_step = 32'h0;
      push_sample(it);
      it.time_step = 32'hFFFFFFFF;
      it.feedback_gain = 32'h0;
      push_sample(it);
    end
    it = plausible_sample();
    it.accel = '{32'sh0, 32'sh0, 32'sh1};
    push_sample(it);
    it.accel = '{32'sh0, 32'sh7FFFFFFF, 32'sh80000000};
    push_sample(it);
    random_phase(100);

    write_gravity(-31'sd536870912, 31'sd536870912, 31'sd0);
    it = plausible_sample();
    it.accel = '{32'sh0, -32'sh10000, 32'sh10000};
    push_sample(it);
    it.accel = '{32'sh0, 32'sh0, 32'sh0};
    push_sample(it);
    random_phase(100);

    send_idle = 78;
    recv_idle = 21;
    write_gravity(31'sd0, 31'sd0, -31'sd536870912);
    random_phase(110);

    send_idle = 0;
    recv_idle = 0;
    write_gravity($signed(31'($urandom_range(0, 31'h40000000))) - 31'sd536870912,
                  $signed(31'($urandom_range(0, 31'h40000000))) - 31'sd536870912,
                  $signed(31'($urandom_range(0, 31'h40000000))) - 31'sd536870912);
    hold_left = 300;
    random_phase(110);

    write_gravity(31'sd536870912, -31'sd536870912, 31'sd536870912);
    random_phase(110);
    wait_idle();

    if (sb.mismatches == 0 && sb.attitude_q.size() == 0) begin
      $display("PASS ahrs_quaternion_update");
    end else begin
      $display("FAIL ahrs_quaternion_update");
    end
    $finish;
  end
endmodule

@@ sim.f @@
src/aqu_pkg.sv
src/aqu_fifo.sv
src/aqu_rsqrt.sv
src/aqu_front.sv
src/aqu_back.sv
src/ahrs_quaternion_update.sv
sim/tb_top.sv
